### design/trpd_pkg.sv
package trpd_pkg;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_SRC_BYTES     = 3'd2;
    localparam logic [2:0] REG_DST_BYTES     = 3'd3;
    localparam logic [2:0] REG_RLE_ENABLED   = 3'd4;
    localparam logic [2:0] REG_TOP_ORIGIN    = 3'd5;
    localparam logic [2:0] REG_RIGHT_ORIGIN  = 3'd6;
    localparam logic [2:0] REG_PALETTE_SKIP  = 3'd7;

    localparam logic [7:0] RLE_REPEAT_BIT = 8'h80;
    localparam logic [7:0] RLE_LEN_MASK   = 8'h7f;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  src_pixel_bytes;
        logic [2:0]  dst_pixel_bytes;
        logic        rle_enabled;
        logic        top_origin;
        logic        right_origin;
        logic [17:0] palette_skip_bytes;
    } trpd_cfg_t;

    // One decoded write, before address generation
    typedef struct packed {
        logic        err;
        logic        last;
        logic [15:0] row;
        logic [15:0] column;
        logic [31:0] value;
        logic [7:0]  count;
    } trpd_event_t;

    // One finished result beat
    typedef struct packed {
        logic [33:0] byte_address;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        status;
        logic        last;
    } trpd_result_t;

    // 0 acts as 1, above 4 acts as 4
    function automatic logic [2:0] clamp_bytes(input logic [2:0] b);
        logic [2:0] r;
        r = b;
        if (b == 3'd0) begin
            r = 3'd1;
        end else if (b > 3'd4) begin
            r = 3'd4;
        end
        return r;
    endfunction

endpackage

### design/trpd_decoder.sv
module trpd_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_frame_start,
    input  trpd_pkg::trpd_cfg_t  cfg,
    output logic                 ev_valid,
    output trpd_pkg::trpd_event_t ev
);
    import trpd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_HEADER,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        fs_reg;

    phase_t      phase_reg, phase_next;
    logic [17:0] skip_reg, skip_next;
    logic [1:0]  bidx_reg, bidx_next;
    logic [31:0] accum_reg, accum_next;
    logic [7:0]  run_reg, run_next;
    logic        rep_reg, rep_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;

    logic        ev_valid_reg, ev_valid_next;
    trpd_event_t ev_reg, ev_next;

    phase_t      data_phase;
    logic [7:0]  pkt_len;
    logic [16:0] col_sum;
    logic [2:0]  sb;
    logic [2:0]  keep;
    logic [7:0]  count;
    logic [31:0] value;

    assign data_phase = cfg.rle_enabled ? PH_HEADER : PH_PIXEL;
    assign sb         = clamp_bytes(cfg.src_pixel_bytes);

    always_comb begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        bidx_next     = bidx_reg;
        accum_next    = accum_reg;
        run_next      = run_reg;
        rep_next      = rep_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ev_valid_next = 1'b0;
        ev_next       = '0;
        pkt_len       = 8'd0;
        col_sum       = 17'd0;
        keep          = 3'd1;
        count         = 8'd1;
        value         = 32'd0;

        if (in_valid_reg) begin
            if (fs_reg) begin
                col_next   = 16'd0;
                row_next   = 16'd0;
                bidx_next  = 2'd0;
                accum_next = 32'd0;
                run_next   = 8'd0;
                rep_next   = 1'b0;
                skip_next  = cfg.palette_skip_bytes;
                if (cfg.image_width == 16'd0 || cfg.image_height == 16'd0) begin
                    phase_next = PH_DONE;
                end else if (cfg.palette_skip_bytes != 18'd0) begin
                    phase_next = PH_SKIP;
                end else begin
                    phase_next = data_phase;
                end
            end

            case (phase_next)
                PH_SKIP: begin
                    skip_next = skip_next - 18'd1;
                    if (skip_next == 18'd0) begin
                        phase_next = data_phase;
                    end
                end
                PH_HEADER: begin
                    pkt_len = (byte_reg & RLE_LEN_MASK) + 8'd1;
                    col_sum = {1'b0, col_next} + {9'd0, pkt_len};
                    if (col_sum > {1'b0, cfg.image_width}) begin
                        // run passes the row end: corrupt, halt
                        ev_valid_next = 1'b1;
                        ev_next.err   = 1'b1;
                        ev_next.last  = 1'b1;
                        phase_next    = PH_DONE;
                    end else begin
                        run_next   = pkt_len;
                        rep_next   = (byte_reg & RLE_REPEAT_BIT) != 8'd0;
                        bidx_next  = 2'd0;
                        accum_next = 32'd0;
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    accum_next[{bidx_next, 3'b000} +: 8] = byte_reg;
                    bidx_next = bidx_next + 2'd1;
                    if ({bidx_next == 2'd0, bidx_next} == sb) begin
                        keep = clamp_bytes(cfg.dst_pixel_bytes);
                        if (sb < keep) begin
                            keep = sb;
                        end
                        case (keep)
                            3'd1:    value = {24'd0, accum_next[7:0]};
                            3'd2:    value = {16'd0, accum_next[15:0]};
                            3'd3:    value = {8'd0, accum_next[23:0]};
                            default: value = accum_next;
                        endcase
                        count = (cfg.rle_enabled && rep_next) ? run_next : 8'd1;
                        if (count == 8'd0) begin
                            count = 8'd1;
                        end

                        ev_valid_next  = 1'b1;
                        ev_next.row    = row_next;
                        ev_next.column = col_next;
                        ev_next.value  = value;
                        ev_next.count  = count;

                        bidx_next  = 2'd0;
                        accum_next = 32'd0;
                        if (cfg.rle_enabled) begin
                            run_next = (run_next >= count) ? run_next - count : 8'd0;
                            if (run_next == 8'd0) begin
                                phase_next = PH_HEADER;
                            end
                        end
                        col_sum = {1'b0, col_next} + {9'd0, count};
                        if (col_sum >= {1'b0, cfg.image_width}) begin
                            col_next = 16'd0;
                            row_next = row_next + 16'd1;
                            if (row_next == 16'd0 || row_next >= cfg.image_height) begin
                                ev_next.last = 1'b1;
                                phase_next   = PH_DONE;
                            end
                        end else begin
                            col_next = col_sum[15:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            skip_reg     <= 18'd0;
            bidx_reg     <= 2'd0;
            accum_reg    <= 32'd0;
            run_reg      <= 8'd0;
            rep_reg      <= 1'b0;
            col_reg      <= 16'd0;
            row_reg      <= 16'd0;
            ev_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= in_valid;
            byte_reg     <= in_byte;
            fs_reg       <= in_frame_start;
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            bidx_reg     <= bidx_next;
            accum_reg    <= accum_next;
            run_reg      <= run_next;
            rep_reg      <= rep_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ev_valid_reg <= ev_valid_next;
            ev_reg       <= ev_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

### design/trpd_addr.sv
module trpd_addr (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  ev_valid,
    input  trpd_pkg::trpd_event_t ev,
    input  trpd_pkg::trpd_cfg_t   cfg,
    output logic                  res_valid,
    output trpd_pkg::trpd_result_t res
);
    import trpd_pkg::*;

    // 32-bit flips: a row or column past the image edge wraps as unsigned
    logic [31:0] drow;
    logic [31:0] dcol;

    logic        valid_reg;
    trpd_event_t ev_reg;
    logic [33:0] prod_reg;
    logic [31:0] dcol_reg;

    logic [33:0] lin;
    logic [33:0] addr;

    assign drow = cfg.top_origin ? {16'd0, ev.row}
                                 : {16'd0, cfg.image_height} - 32'd1 - {16'd0, ev.row};
    assign dcol = cfg.right_origin ? {16'd0, cfg.image_width} - 32'd1 - {16'd0, ev.column}
                                   : {16'd0, ev.column};

    // stage: row * width, kept to the 34 address bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ev_valid;
            ev_reg    <= ev;
            prod_reg  <= 34'(drow * {16'd0, cfg.image_width});
            dcol_reg  <= dcol;
        end
    end

    // pixel index times 1..4 bytes: shift/add only
    assign lin = prod_reg + {2'd0, dcol_reg};

    always_comb begin
        case (clamp_bytes(cfg.dst_pixel_bytes))
            3'd1:    addr = lin;
            3'd2:    addr = {lin[32:0], 1'b0};
            3'd3:    addr = lin + {lin[32:0], 1'b0};
            default: addr = {lin[31:0], 2'b00};
        endcase
        res.byte_address = ev_reg.err ? 34'd0 : addr;
        res.pixel_value  = ev_reg.value;
        res.repeat_count = ev_reg.count;
        res.status       = ev_reg.err;
        res.last         = ev_reg.last;
    end

    assign res_valid = valid_reg;

endmodule

### design/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder.
// Input channel (s_*): one beat per byte of the image data stream that
// follows the file header. s_frame_start marks the first byte of an image;
// decoding restarts there. Palette bytes are dropped, then RLE packets (or
// plain pixels with RLE off) are decoded into destination writes.
// Output channel (m_*): one beat per pixel, or per whole repeat run, giving
// the destination byte address (top/right origin applied), the pixel value
// trimmed to the destination size, and the number of pixels it covers.
// A run that crosses a row end gives one beat with status 1 and last 1, and
// the block then ignores bytes until the next frame start.
// Throughput: one byte per cycle while the output is not stalled. A result
// is registered through the input reg, decode reg, row*width multiply reg
// and output reg after the byte that completes it is accepted.
// Back-pressure: all four stages advance together; when m_valid is high and
// m_ready low, the pipe holds and s_ready drops in the same cycle.
// Reset (aresetn low, synchronous): pipe emptied, decoder back to idle,
// registers to their defaults. Bytes before the first frame start are dropped.
// Registers: APB, word per register at 4*index; write only while idle.
module tga_rle_pixel_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [33:0] m_byte_address,
    output logic [31:0] m_pixel_value,
    output logic [7:0]  m_repeat_count,
    output logic        m_status,
    output logic        m_last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import trpd_pkg::*;

    trpd_cfg_t    cfg_reg;
    logic         en;
    logic         cfg_wr;

    logic         ev_valid;
    trpd_event_t  ev;
    logic         res_valid;
    trpd_result_t res;

    logic         m_valid_reg;
    trpd_result_t res_reg;

    // whole pipe moves when the output slot is free or being drained
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width        <= 16'd0;
            cfg_reg.image_height       <= 16'd0;
            cfg_reg.src_pixel_bytes    <= 3'd3;
            cfg_reg.dst_pixel_bytes    <= 3'd4;
            cfg_reg.rle_enabled        <= 1'b1;
            cfg_reg.top_origin         <= 1'b0;
            cfg_reg.right_origin       <= 1'b0;
            cfg_reg.palette_skip_bytes <= 18'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  cfg_reg.image_width        <= pwdata[15:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height       <= pwdata[15:0];
                REG_SRC_BYTES:    cfg_reg.src_pixel_bytes    <= pwdata[2:0];
                REG_DST_BYTES:    cfg_reg.dst_pixel_bytes    <= pwdata[2:0];
                REG_RLE_ENABLED:  cfg_reg.rle_enabled        <= pwdata[0];
                REG_TOP_ORIGIN:   cfg_reg.top_origin         <= pwdata[0];
                REG_RIGHT_ORIGIN: cfg_reg.right_origin       <= pwdata[0];
                REG_PALETTE_SKIP: cfg_reg.palette_skip_bytes <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = {16'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_reg.image_height};
            REG_SRC_BYTES:    prdata = {29'd0, cfg_reg.src_pixel_bytes};
            REG_DST_BYTES:    prdata = {29'd0, cfg_reg.dst_pixel_bytes};
            REG_RLE_ENABLED:  prdata = {31'd0, cfg_reg.rle_enabled};
            REG_TOP_ORIGIN:   prdata = {31'd0, cfg_reg.top_origin};
            REG_RIGHT_ORIGIN: prdata = {31'd0, cfg_reg.right_origin};
            REG_PALETTE_SKIP: prdata = {14'd0, cfg_reg.palette_skip_bytes};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- datapath ----------------
    // input reg + packet/pixel state machine -> event reg
    trpd_decoder u_decoder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .in_byte        (s_data_byte),
        .in_frame_start (s_frame_start),
        .cfg            (cfg_reg),
        .ev_valid       (ev_valid),
        .ev             (ev)
    );

    // origin flip, row*width reg, then scale by destination pixel bytes
    trpd_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= res_valid;
            res_reg     <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = res_reg.byte_address;
    assign m_pixel_value  = res_reg.pixel_value;
    assign m_repeat_count = res_reg.repeat_count;
    assign m_status       = res_reg.status;
    assign m_last         = res_reg.last;

endmodule

### design/trpd_checker.sv
module trpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [33:0] m_byte_address,
    input logic [31:0] m_pixel_value,
    input logic [7:0]  m_repeat_count,
    input logic        m_status,
    input logic        m_last
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_address)
            && $stable(m_pixel_value) && $stable(m_repeat_count)
            && $stable(m_status) && $stable(m_last))
        else $error("result beat changed while stalled");

    // pipe is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // corrupt beat ends the image
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last)
        else $error("corrupt beat without last");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_byte_address == 34'd0 && m_pixel_value == 32'd0
            && m_repeat_count == 8'd0)
        else $error("corrupt beat carries payload");

    // a good write covers 1..128 pixels
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_repeat_count != 8'd0 && m_repeat_count <= 8'd128)
        else $error("repeat count out of range");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

### tb/sv/tb_tga_rle_pixel_decoder.sv
module tb_tga_rle_pixel_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import trpd_pkg::*;

    // Random part stops once this many bytes have reached a live decoder
    localparam int unsigned RANDOM_ITEMS = 400;
    // Cycles with no beat on either channel before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Settle time after the last expected write: 4-stage pipe plus margin
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_SKIP,
        DEC_HEADER,
        DEC_PIXEL,
        DEC_DONE
    } dec_phase_e;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_frame_start;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [33:0] m_byte_address;
    logic [31:0] m_pixel_value;
    logic [7:0]  m_repeat_count;
    logic        m_status;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tga_rle_pixel_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_pixel_value  (m_pixel_value),
        .m_repeat_count (m_repeat_count),
        .m_status       (m_status),
        .m_last         (m_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder shadow: register copy plus the byte-level decode state.
    // Updated at the edge that accepts each input beat.
    // ------------------------------------------------------------------
    trpd_cfg_t    fmt;
    dec_phase_e   dec_phase;
    logic [17:0]  skip_left;
    logic [1:0]   byte_pos;
    logic [31:0]  pix_acc;
    logic [7:0]   run_left;
    logic         run_repeat;
    logic [15:0]  col;
    logic [15:0]  row;
    logic         halted;
    bit           byte_live;   // last beat reached an active decoder

    trpd_result_t pending_writes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  rx_tick = 0;
    int unsigned  rx_hold = 0;
    int unsigned  quiet_cycles = 0;

    // Byte counts: zero behaves as one, anything past four as four
    function automatic int unsigned eff_bytes(input logic [2:0] b);
        if (b == 3'd0) return 1;
        if (b > 3'd4) return 4;
        return 32'(b);
    endfunction

    function automatic logic [7:0] rle_header(input bit rep, input int unsigned n);
        logic [7:0] len;
        len = 8'(n - 1);
        return (rep ? RLE_REPEAT_BIT : 8'h00) | (len & RLE_LEN_MASK);
    endfunction

    // Works out the write (if any) that one accepted byte causes and queues it.
    task automatic decode_byte(input logic [7:0] b, input logic fs);
        int unsigned  n, sb, keep, cnt, col_next;
        logic [31:0]  drow, dcol, value;
        logic [63:0]  addr;
        trpd_result_t wr;
        byte_live = 1'b0;
        if (fs) begin
            halted = 1'b0; col = '0; row = '0; byte_pos = '0; pix_acc = '0;
            run_left = '0; run_repeat = 1'b0;
            skip_left = fmt.palette_skip_bytes;
            if (fmt.image_width == 0 || fmt.image_height == 0) begin
                dec_phase = DEC_DONE;
            end else if (skip_left != 0) begin
                dec_phase = DEC_SKIP;
            end else begin
                dec_phase = fmt.rle_enabled ? DEC_HEADER : DEC_PIXEL;
            end
        end
        if (halted || dec_phase == DEC_IDLE || dec_phase == DEC_DONE) return;
        byte_live = 1'b1;

        if (dec_phase == DEC_SKIP) begin
            skip_left = skip_left - 1'b1;
            if (skip_left == 0) dec_phase = fmt.rle_enabled ? DEC_HEADER : DEC_PIXEL;
            return;
        end

        if (dec_phase == DEC_HEADER) begin
            n = (b & RLE_LEN_MASK) + 1;
            if (col + n > fmt.image_width) begin
                // packet runs past the row end: one error beat, then halt
                wr = '0;
                wr.status = 1'b1;
                wr.last = 1'b1;
                pending_writes.push_back(wr);
                halted = 1'b1;
                dec_phase = DEC_DONE;
                return;
            end
            run_left = 8'(n);
            run_repeat = (b & RLE_REPEAT_BIT) != 0;
            byte_pos = '0;
            pix_acc = '0;
            dec_phase = DEC_PIXEL;
            return;
        end

        // pixel byte, first byte lands lowest
        pix_acc = pix_acc | (32'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 1'b1;
        sb = eff_bytes(fmt.src_pixel_bytes);
        if ((byte_pos == 0 ? 4 : byte_pos) != sb) return;

        keep = eff_bytes(fmt.dst_pixel_bytes);
        if (sb < keep) keep = sb;
        value = (keep >= 4) ? pix_acc : pix_acc & ((32'd1 << (8 * keep)) - 32'd1);
        cnt = (fmt.rle_enabled && run_repeat) ? run_left : 1;
        if (cnt == 0) cnt = 1;

        drow = fmt.top_origin ? 32'(row) : 32'(fmt.image_height) - 32'd1 - 32'(row);
        dcol = fmt.right_origin ? 32'(fmt.image_width) - 32'd1 - 32'(col) : 32'(col);
        addr = (64'(drow) * 64'(fmt.image_width) + 64'(dcol))
               * 64'(eff_bytes(fmt.dst_pixel_bytes));

        wr.byte_address = addr[33:0];
        wr.pixel_value  = value;
        wr.repeat_count = 8'(cnt);
        wr.status       = 1'b0;
        wr.last         = 1'b0;

        byte_pos = '0;
        pix_acc = '0;
        if (fmt.rle_enabled) begin
            run_left = (run_left >= cnt) ? run_left - 8'(cnt) : 8'd0;
            if (run_left == 0) dec_phase = DEC_HEADER;
        end
        col_next = col + cnt;
        if (col_next >= fmt.image_width) begin
            col = '0;
            row = row + 1'b1;
            if (row == 0 || row >= fmt.image_height) begin
                wr.last = 1'b1;
                dec_phase = DEC_DONE;
            end
        end else begin
            col = col_next[15:0];
        end
        pending_writes.push_back(wr);
    endtask

    // ------------------------------------------------------------------
    // Input side. One byte per call; valid stays up across back-to-back
    // beats and only drops when a burst ends and a gap is taken.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic fs);
        int unsigned gap;
        s_valid       <= 1'b1;
        s_data_byte   <= d;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(d, fs);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Block is idle once every queued write is back and the pipe has settled;
    // header and skip bytes leave no write behind, hence the extra cycles.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup, then access; lands at the edge with pready high
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  fmt.image_width        = val[15:0];
            REG_IMAGE_HEIGHT: fmt.image_height       = val[15:0];
            REG_SRC_BYTES:    fmt.src_pixel_bytes    = val[2:0];
            REG_DST_BYTES:    fmt.dst_pixel_bytes    = val[2:0];
            REG_RLE_ENABLED:  fmt.rle_enabled        = val[0];
            REG_TOP_ORIGIN:   fmt.top_origin         = val[0];
            REG_RIGHT_ORIGIN: fmt.right_origin       = val[0];
            REG_PALETTE_SKIP: fmt.palette_skip_bytes = val[17:0];
            default: ;
        endcase
    endtask

    task automatic set_format(input int unsigned w, h, src, dst, rle, top, right, skip);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SRC_BYTES, src);
        write_reg(REG_DST_BYTES, dst);
        write_reg(REG_RLE_ENABLED, rle);
        write_reg(REG_TOP_ORIGIN, top);
        write_reg(REG_RIGHT_ORIGIN, right);
        write_reg(REG_PALETTE_SKIP, skip);
    endtask

    // Next stream byte for a well-formed frame. Headers are sized to fit the
    // rest of the row, except for the odd deliberately corrupt or wild one.
    function automatic logic [7:0] pick_byte(input bit start);
        dec_phase_e  ph;
        int unsigned rem, n;
        if (start) begin
            rem = 32'(fmt.image_width);
            if (fmt.image_width == 0 || fmt.image_height == 0) ph = DEC_DONE;
            else if (fmt.palette_skip_bytes != 0) ph = DEC_SKIP;
            else ph = fmt.rle_enabled ? DEC_HEADER : DEC_PIXEL;
        end else begin
            rem = (col < fmt.image_width) ? 32'(fmt.image_width) - 32'(col) : 1;
            ph = dec_phase;
        end
        if (ph != DEC_HEADER || $urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
        if (rem < 128 && $urandom_range(0, 24) == 0) begin
            n = $urandom_range(rem + 1, 128);
        end else begin
            if (rem > 128) rem = 128;
            n = ($urandom_range(0, 3) == 0) ? rem : $urandom_range(1, rem);
        end
        return rle_header(1'($urandom_range(0, 1)), n);
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver back-pressure steps through four modes in turn,
    // picked by rx_tick[9:8]: always ready, random drops, stall bursts, toggling ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
                if (rx_hold > 0) begin
                    m_ready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else if ($urandom_range(0, 9) == 0) begin
                    m_ready <= 1'b0;
                    rx_hold <= $urandom_range(1, 7);
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: m_ready <= rx_tick[0];
        endcase
    end

    // Every result beat is matched against the oldest queued write
    always @(posedge aclk) begin : check_writes
        trpd_result_t exp_wr;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write beat: byte_address %0h pixel_value %0h",
                       m_byte_address, m_pixel_value);
                mismatch_count++;
            end else begin
                exp_wr = pending_writes.pop_front();
                if (m_byte_address !== exp_wr.byte_address) begin
                    $error("byte_address: expected %0h, got %0h",
                           exp_wr.byte_address, m_byte_address);
                    mismatch_count++;
                end
                if (m_pixel_value !== exp_wr.pixel_value) begin
                    $error("pixel_value: expected %0h, got %0h",
                           exp_wr.pixel_value, m_pixel_value);
                    mismatch_count++;
                end
                if (m_repeat_count !== exp_wr.repeat_count) begin
                    $error("repeat_count: expected %0d, got %0d",
                           exp_wr.repeat_count, m_repeat_count);
                    mismatch_count++;
                end
                if (m_status !== exp_wr.status) begin
                    $error("status: expected %0b, got %0b", exp_wr.status, m_status);
                    mismatch_count++;
                end
                if (m_last !== exp_wr.last) begin
                    $error("last: expected %0b, got %0b", exp_wr.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detector: no beat on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves a 0x0 image: bytes before any start, and a start on an
    // empty image, must all be dropped without a write.
    task automatic test_ignored_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b0);
    endtask

    // Plain pixels, RLE off, two palette bytes first. Source size 0 acts as
    // one byte, destination 7 as four. Byte after the final pixel is dropped.
    task automatic test_raw_pixels();
        wait_quiet();
        set_format(2, 2, 0, 7, 0, 0, 0, 2);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h77, 1'b0);
    endtask

    // Repeat packet then raw packet, top/right origin, 4-byte source
    // trimmed to a 2-byte destination.
    task automatic test_rle_packets();
        wait_quiet();
        set_format(3, 1, 4, 2, 1, 1, 1, 0);
        send_byte(rle_header(1'b1, 2), 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(rle_header(1'b0, 1), 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'hD2, 1'b0);
        send_byte(8'hC3, 1'b0);
    endtask

    // Packet longer than the row: error beat, then the decoder sits halted
    task automatic test_corrupt_run();
        wait_quiet();
        set_format(2, 2, 3, 3, 1, 0, 0, 0);
        send_byte(rle_header(1'b0, 3), 1'b1);
        send_byte(8'h99, 1'b0);
    endtask

    // Largest image with all-ones palette skip, cut short by a restart;
    // then a full 128-pixel run at the far corner, and register changes
    // between packets of the same image.
    task automatic test_extremes();
        wait_quiet();
        set_format(65535, 65535, 4, 4, 1, 0, 1, 32'h3FFFF);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h81, 1'b0);
        wait_quiet();
        write_reg(REG_PALETTE_SKIP, 0);
        send_byte(rle_header(1'b1, 128), 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_quiet();
        write_reg(REG_SRC_BYTES, 1);
        write_reg(REG_TOP_ORIGIN, 1);
        send_byte(rle_header(1'b0, 1), 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    // Random formats and frames. Mostly small images run to completion;
    // some huge ones are cut off after a few bytes. Occasional restarts
    // mid-frame, empty images and trailing noise after the image ends.
    task automatic test_random_frames();
        int unsigned live_items, limit, sent, w, h;
        bit          start;
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(0, 1) ? 65535 : $urandom_range(200, 65535);
                h = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
                limit = $urandom_range(6, 60);
            end else begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 4);
                limit = 400;
            end
            if ($urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1)) w = 0;
                else h = 0;
            end
            wait_quiet();
            set_format(w, h, $urandom_range(0, 7), $urandom_range(0, 7),
                       ($urandom_range(0, 3) != 0) ? 1 : 0,
                       $urandom_range(0, 1), $urandom_range(0, 1),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
            start = 1'b1;
            sent = 0;
            while (sent < limit && (start || dec_phase != DEC_DONE)) begin
                send_byte(pick_byte(start), start);
                live_items += 32'(byte_live);
                sent++;
                start = ($urandom_range(0, 59) == 0);
            end
            repeat ($urandom_range(0, 2)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                live_items += 32'(byte_live);
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_frame_start = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // register defaults and an idle decoder, as after reset
        fmt = '0;
        fmt.src_pixel_bytes = 3'd3;
        fmt.dst_pixel_bytes = 3'd4;
        fmt.rle_enabled = 1'b1;
        dec_phase = DEC_IDLE;
        skip_left = '0; byte_pos = '0; pix_acc = '0; run_left = '0;
        run_repeat = 1'b0; col = '0; row = '0; halted = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_bytes();
        test_raw_pixels();
        test_rle_packets();
        test_corrupt_run();
        test_extremes();
        test_random_frames();

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
